// File: rtl/rbf_pkg.sv
// rbf_pkg: shared types, constants and helpers of the 3x3 rgb box filter
// used by every module of the filter; no dependencies

package rbf_pkg;

	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int WIN_SIZE   = 3;
	localparam int WIN_TAPS   = WIN_SIZE * WIN_SIZE;
	localparam int SUM_W      = 12;
	localparam int COL_OUT_W  = 10;
	localparam int ROW_W      = 16;
	localparam int IMG_W_W    = 11;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 56;

	localparam int QDEPTH     = 4;
	localparam int QAW        = 2;
	localparam int QCW        = 3;

	// floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
	localparam logic [12:0] DIV9_MUL   = 13'd7282;
	localparam int          DIV9_SHIFT = 16;

	localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [ROW_W-1:0]   HEIGHT_RST = 16'd480;

	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic [IMG_W_W-1:0] image_width;
		logic [ROW_W-1:0]   image_height;
		logic               restart;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0]     sum_red;
		logic [SUM_W-1:0]     sum_green;
		logic [SUM_W-1:0]     sum_blue;
		logic [COL_OUT_W-1:0] center_col;
		logic [ROW_W-1:0]     center_row;
		logic                 frame_last;
	} q_item_t;

	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [24:0] prod;
		prod = 25'(s) * 25'(DIV9_MUL);
		return prod[DIV9_SHIFT +: CH_W];
	endfunction

endpackage

// File: rtl/rgb_box_filter_3x3_unit.sv
// rgb_box_filter_3x3_unit: top level of the 3x3 rgb mean filter
// depends on rbf_pkg, rbf_front, rbf_queue, rbf_back
//
// usage:
//   s_* carries one rgb pixel per beat in raster order; m_* carries one beat
//   per interior pixel of the frame: the truncated mean of its 3x3
//   neighbourhood per channel plus the centre coordinates, tlast on the last
//   filtered pixel of the frame. border pixels and frames narrower or lower
//   than three give no output beat.
//   register 0 (byte 0) is the width, register 1 (byte 4) the height; a write
//   restarts the frame and is meant for an idle block.
//   throughput is one pixel per clock while s_tready is high, held by the line
//   store taking one read and one write in every cycle; a completed window
//   passes the intake, window, queue and output registers to its result beat.
//   reset clears the counters, window and queue and loads 640 x 480; the line
//   store needs no clearing, as rows 0 and 1 rewrite it before any use.
//   when the receiver stalls, results wait in a four deep queue and s_tready
//   drops once the queue and the pipeline behind it can take no more.

module rgb_box_filter_3x3_unit import rbf_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // red_in, green_in, blue_in
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // red_mean, green_mean, blue_mean, center_col, center_row
	output logic                 m_tlast    // frame_last
);

	logic [IMG_W_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;
	logic               wr_en;
	cfg_t               cfg;
	logic               push;
	q_item_t            push_item;
	logic               pop;
	logic               head_valid;
	q_item_t            head_item;
	logic [QCW-1:0]     q_count;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[ADDR_W-1])
				REG_IDX_WIDTH:  width_q  <= pwdata[IMG_W_W-1:0];
				REG_IDX_HEIGHT: height_q <= pwdata[ROW_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1])
			REG_IDX_WIDTH:  prdata = DATA_W'(width_q);
			REG_IDX_HEIGHT: prdata = DATA_W'(height_q);
		endcase
	end

	assign cfg.image_width  = width_q;
	assign cfg.image_height = height_q;
	assign cfg.restart      = wr_en;

	rbf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_count   (q_count),
		.push      (push),
		.push_item (push_item)
	);

	rbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.count      (q_count)
	);

	rbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// File: rtl/rbf_front.sv
// rbf_front: pixel intake, raster counters, line stores, 3x3 window and channel sums
// depends on rbf_pkg; feeds rbf_queue

module rbf_front import rbf_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [QCW-1:0]       q_count,
	output logic                 push,
	output q_item_t              push_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > IMG_W_W) ? WW : IMG_W_W;
	localparam int XW = (CW > COL_OUT_W) ? CW : COL_OUT_W;

	// upper line in the high half, middle line in the low half
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [CW-1:0]      c_q;
	logic [ROW_W-1:0]   r_q;
	logic [EW-1:0]      w_eff;
	logic [ROW_W-1:0]   h_eff;
	logic [EW-1:0]      c_inc;
	logic [ROW_W:0]     r_inc;
	logic               line_end;
	logic               frame_end;
	logic               accept;
	logic               emit;
	logic               last;
	logic [XW-1:0]      ccol_full;
	pixel_t             pix;

	logic               valid_s1;
	pixel_t             pix_s1;
	logic [CW-1:0]      c_s1;
	logic               emit_s1;
	logic               last_s1;
	logic [COL_OUT_W-1:0] ccol_s1;
	logic [ROW_W-1:0]   crow_s1;
	logic [2*PIX_W-1:0] rd_s1;

	pixel_t             win_q   [WIN_TAPS];
	pixel_t             win_nxt [WIN_TAPS];
	logic [SUM_W-1:0]   sum_r, sum_g, sum_b;

	logic               valid_s2;
	logic               emit_s2;
	q_item_t            item_s2;

	always_comb begin
		w_eff = EW'(cfg.image_width);
		if (w_eff == '0) begin
			w_eff = EW'(1);
		end else if (w_eff > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end
		h_eff = (cfg.image_height == '0) ? ROW_W'(1) : cfg.image_height;
	end

	assign c_inc     = EW'(c_q) + EW'(1);
	assign r_inc     = {1'b0, r_q} + (ROW_W+1)'(1);
	assign line_end  = c_inc >= w_eff;
	assign frame_end = r_inc >= {1'b0, h_eff};
	assign emit      = (w_eff >= EW'(WIN_SIZE)) && (h_eff >= ROW_W'(WIN_SIZE))
		&& (c_q >= CW'(WIN_SIZE - 1)) && (r_q >= ROW_W'(WIN_SIZE - 1));
	assign last      = (c_inc == w_eff) && (r_inc == {1'b0, h_eff});
	assign ccol_full = XW'(c_q) - XW'(1);
	assign pix       = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

	// room for everything in flight behind the queue
	assign s_tready = (q_count + QCW'(valid_s1) + QCW'(valid_s2)) < QCW'(QDEPTH);
	assign accept   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (cfg.restart) begin
			c_q <= '0;
			r_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				c_q <= '0;
				r_q <= frame_end ? '0 : r_inc[ROW_W-1:0];
			end else begin
				c_q <= c_inc[CW-1:0];
			end
		end
	end

	// line store: read on intake, write back in the next cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[c_q];
		end
		if (valid_s1) begin
			line_mem[c_s1] <= {rd_s1[PIX_W-1:0], pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix;
			c_s1    <= c_q;
			emit_s1 <= emit;
			last_s1 <= last;
			ccol_s1 <= ccol_full[COL_OUT_W-1:0];
			crow_s1 <= r_q - ROW_W'(1);
		end
	end

	always_comb begin
		for (int k = 0; k < WIN_SIZE; k++) begin
			win_nxt[k*WIN_SIZE]     = win_q[k*WIN_SIZE + 1];
			win_nxt[k*WIN_SIZE + 1] = win_q[k*WIN_SIZE + 2];
		end
		win_nxt[2] = rd_s1[2*PIX_W-1:PIX_W];
		win_nxt[5] = rd_s1[PIX_W-1:0];
		win_nxt[8] = pix_s1;
	end

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int k = 0; k < WIN_TAPS; k++) begin
			sum_r = sum_r + SUM_W'(win_nxt[k][23:16]);
			sum_g = sum_g + SUM_W'(win_nxt[k][15:8]);
			sum_b = sum_b + SUM_W'(win_nxt[k][7:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_TAPS; k++) begin
				win_q[k] <= '0;
			end
			valid_s2 <= 1'b0;
		end else begin
			if (valid_s1) begin
				win_q <= win_nxt;
			end
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			emit_s2              <= emit_s1;
			item_s2.sum_red      <= sum_r;
			item_s2.sum_green    <= sum_g;
			item_s2.sum_blue     <= sum_b;
			item_s2.center_col   <= ccol_s1;
			item_s2.center_row   <= crow_s1;
			item_s2.frame_last   <= last_s1;
		end
	end

	assign push      = valid_s2 & emit_s2;
	assign push_item = item_s2;

endmodule

// File: rtl/rbf_queue.sv
// rbf_queue: short fifo of window sums between front and back
// depends on rbf_pkg

module rbf_queue import rbf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  q_item_t        push_item,
	input  logic           pop,
	output logic           head_valid,
	output q_item_t        head_item,
	output logic [QCW-1:0] count
);

	q_item_t        entries_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_pop;

	assign head_valid = count_q != '0;
	assign head_item  = entries_q[rd_ptr_q];
	assign count      = count_q;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(do_pop);
		end
	end

endmodule

// File: rtl/rbf_back.sv
// rbf_back: divides queued sums by nine and holds the result beat for the receiver
// depends on rbf_pkg; drains rbf_queue

module rbf_back import rbf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  q_item_t              head_item,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	logic                 m_tvalid_q;
	logic [CH_W-1:0]      red_q, green_q, blue_q;
	logic [COL_OUT_W-1:0] col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 last_q;

	assign pop = head_valid & (~m_tvalid_q | m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			red_q   <= div9(head_item.sum_red);
			green_q <= div9(head_item.sum_green);
			blue_q  <= div9(head_item.sum_blue);
			col_q   <= head_item.center_col;
			row_q   <= head_item.center_row;
			last_q  <= head_item.frame_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, row_q, col_q, blue_q, green_q, red_q};
	assign m_tlast  = last_q;

endmodule

// File: rtl/rbf_checker.sv
// rbf_checker: port level assertions for rgb_box_filter_3x3_unit and its bind
// depends on rbf_pkg

module rbf_checker import rbf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [ADDR_W-1:0]    paddr,
	input logic [DATA_W-1:0]    pwdata,
	input logic [DATA_W-1:0]    prdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast
);

	// a stalled result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// only interior centres leave: row field is never zero, pad bits stay clear
	a_out_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[49:34] != '0) && (m_tdata[55:50] == '0))
		else $error("result beat outside the frame interior");

	a_width_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[ADDR_W-1] == REG_IDX_WIDTH)
		|=> (paddr[ADDR_W-1] != REG_IDX_WIDTH)
			|| (prdata == DATA_W'($past(pwdata[IMG_W_W-1:0]))))
		else $error("width register does not read back");

	a_height_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[ADDR_W-1] == REG_IDX_HEIGHT)
		|=> (paddr[ADDR_W-1] != REG_IDX_HEIGHT)
			|| (prdata == DATA_W'($past(pwdata[ROW_W-1:0]))))
		else $error("height register does not read back");

	// reset held across an edge keeps the output quiet
	a_reset_idle: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> !m_tvalid)
		else $error("result beat during reset");

endmodule

bind rgb_box_filter_3x3_unit rbf_checker u_rbf_checker (.*);
